// File: hdl/ppmp_pkg.sv
// Package for the polar plotter move planner.
// Holds register reset values, register indexes, the sequencer states and the result layout.
// No dependencies; every other file in hdl/ imports it.
package ppmp_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam logic [15:0] RST_STEP_LENGTH    = 16'd12353;
	localparam logic [9:0]  RST_FEED_SPEED     = 10'd16;
	localparam logic [11:0] RST_MOTOR_DISTANCE = 12'd950;
	localparam logic [11:0] RST_START_HEIGHT   = 12'd260;

	localparam logic [9:0]  MS_PER_S = 10'd1000;
	localparam int          DIV_BITS = 16;

	localparam logic [1:0] REG_STEP_LENGTH    = 2'd0;
	localparam logic [1:0] REG_FEED_SPEED     = 2'd1;
	localparam logic [1:0] REG_MOTOR_DISTANCE = 2'd2;
	localparam logic [1:0] REG_START_HEIGHT   = 2'd3;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Division jobs run in this order during planning.
	localparam logic [2:0] JOB_STEPS_L  = 3'd0;
	localparam logic [2:0] JOB_STEPS_R  = 3'd1;
	localparam logic [2:0] JOB_DURATION = 3'd2;
	localparam logic [2:0] JOB_PERIOD_L = 3'd3;
	localparam logic [2:0] JOB_PERIOD_R = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_DIFF,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_COMMIT,
		ST_TICK_INC,
		ST_TICK_EVAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        rejected;
		logic        moving;
		logic        pulse_right;
		logic        pulse_left;
		logic [31:0] move_duration;
		logic [15:0] steps_right;
		logic [15:0] steps_left;
		logic        reel_out_right;
		logic        reel_out_left;
	} result_t;

endpackage

// File: hdl/ppmp_isqrt.sv
// Bit-serial integer square root: one root bit per cycle, two radicand bits shifted in per cycle.
// Used by the move planner for the string lengths. Depends on ppmp_pkg.
module ppmp_isqrt
	import ppmp_pkg::*;
#(
	parameter int LW = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*LW-1:0]   radicand,
	output logic [LW-1:0]     root,
	output logic              done
);

	localparam int CNTW = $clog2(LW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [2*LW-1:0] rad_q;
	logic [LW+1:0]   rem_q;
	logic [LW-1:0]   root_q;

	logic [LW+1:0] rem_shift;
	logic [LW+1:0] trial;
	logic          fits;

	assign rem_shift = {rem_q[LW-1:0], rad_q[2*LW-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign fits      = rem_shift >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(LW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*LW-3:0], 2'b00};
			rem_q  <= fits ? rem_shift - trial : rem_shift;
			root_q <= {root_q[LW-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// File: hdl/ppmp_divider.sv
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// Shared by the step count, duration and period calculations. Depends on ppmp_pkg.
module ppmp_divider
	import ppmp_pkg::*;
#(
	parameter int NW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NW-1:0]       dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output logic [NW-1:0]       quotient,
	output logic                done
);

	localparam int CNTW = $clog2(NW);

	logic                busy_q;
	logic                done_q;
	logic [CNTW-1:0]     cnt_q;
	logic [NW-1:0]       num_q;
	logic [DIV_BITS-1:0] den_q;
	logic [DIV_BITS:0]   rem_q;

	logic [DIV_BITS:0] rem_shift;
	logic              fits;

	assign rem_shift = {rem_q[DIV_BITS-1:0], num_q[NW-1]};
	assign fits      = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_shift - {1'b0, den_q} : rem_shift;
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

// File: hdl/polar_plotter_move_planner.sv
// Polar plotter move planner: top level with the sequencer, position and timing state.
// Instantiates ppmp_isqrt and ppmp_divider; depends on ppmp_pkg.
//
// Input beats on s_*: s_tuser is the operation (0 move, 1 millisecond tick), s_tdata carries
// target_x and target_y. Every input beat gives exactly one result beat on m_*.
// A move works out four string lengths in turn on one bit-serial square root unit
// (LW = max(COORD_BITS,12)+9) and then up to five divisions on one bit-serial divider
// (DW = max(LW+10,32)). One item is in the block at a time: s_tready is high only while
// idle, and the result waits in the output register until m_tready takes it, the block
// accepting nothing meanwhile. Configuration writes on cfg_* act at once; writing the
// motor distance or the start height reloads the position.
// Reset loads the default registers, puts the pen at (distance/2, start height) and
// leaves no move active.
module polar_plotter_move_planner
	import ppmp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic                               s_tuser, // operation
	// target_x, target_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// reel_out_left, reel_out_right, steps_left, steps_right, move_duration,
	// pulse_left, pulse_right, moving, rejected, zero fill
	output logic [71:0]                        m_tdata,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);

	localparam int C  = COORD_BITS;
	localparam int AW = (C > 12) ? C : 12;
	localparam int LW = AW + 9;
	localparam int RW = 2 * LW;
	localparam int DW = (LW + 10 > 32) ? LW + 10 : 32;

	state_t state_q, state_d;

	// configuration and move state
	logic [15:0]   step_len_q;
	logic [9:0]    feed_q;
	logic [11:0]   md_q;
	logic [11:0]   sh_q;
	logic [C-1:0]  px_q, py_q;
	logic [23:0]   elapsed_q;
	logic [31:0]   dur_q;
	logic [31:0]   per_l_q, per_r_q;
	logic [31:0]   tim_l_q, tim_r_q;
	logic [1:0]    dir_q;
	logic          active_q;
	logic [1:0]    k_q;
	logic [2:0]    j_q;

	// item payload and working values
	logic          op_q;
	logic [C-1:0]  tx_q, ty_q;
	logic [2*AW-1:0] sq_a_q, sq_b_q;
	logic [LW-1:0] len_q [4];
	logic [LW-1:0] ml_q, mr_q;
	logic [LW+9:0] prod_q;
	logic [15:0]   steps_l_q, steps_r_q;
	result_t       out_q;

	logic          accept;
	logic          sqrt_start, sqrt_done, div_start, div_done;
	logic [LW-1:0] root;
	logic [DW-1:0] quot;
	logic [RW-1:0] radicand;
	logic [DW-1:0] div_num;
	logic [15:0]   div_den;
	logic          div_skip;

	assign accept = s_tvalid && s_tready;

	// Operand selection for the squares: index bit 1 picks the target, bit 0 the right string.
	logic [AW-1:0]   x_sel, y_sel, md_ext, dx;
	logic [2*AW-1:0] sq_x, sq_y;
	logic [2*AW:0]   sq_sum;

	assign x_sel  = k_q[1] ? AW'(tx_q) : AW'(px_q);
	assign y_sel  = k_q[1] ? AW'(ty_q) : AW'(py_q);
	assign md_ext = AW'(md_q);
	assign dx     = !k_q[0] ? x_sel : ((md_ext >= x_sel) ? md_ext - x_sel : x_sel - md_ext);
	assign sq_x   = dx * dx;
	assign sq_y   = y_sel * y_sel;
	assign sq_sum = {1'b0, sq_a_q} + {1'b0, sq_b_q};
	assign radicand = RW'({sq_sum, 16'h0000});

	// Length changes; len_q holds left now, right now, left target, right target.
	logic [LW-1:0] ml, mr, mx;
	logic          out_l, out_r;

	assign out_l = len_q[2] > len_q[0];
	assign out_r = len_q[3] > len_q[1];
	assign ml    = out_l ? len_q[2] - len_q[0] : len_q[0] - len_q[2];
	assign mr    = out_r ? len_q[3] - len_q[1] : len_q[1] - len_q[3];
	assign mx    = (ml > mr) ? ml : mr;

	// Division operands for the current job.
	always_comb begin
		div_num  = '0;
		div_den  = 16'd1;
		div_skip = 1'b0;
		case (j_q)
			JOB_STEPS_L: begin
				div_num = DW'({ml_q, 8'h00});
				div_den = (step_len_q == 16'd0) ? 16'd1 : step_len_q;
			end
			JOB_STEPS_R: begin
				div_num = DW'({mr_q, 8'h00});
				div_den = (step_len_q == 16'd0) ? 16'd1 : step_len_q;
			end
			JOB_DURATION: begin
				div_num = DW'(prod_q);
				div_den = (feed_q == 10'd0) ? 16'd1 : 16'(feed_q);
			end
			JOB_PERIOD_L: begin
				div_num  = DW'(dur_q);
				div_den  = steps_l_q;
				div_skip = steps_l_q == 16'd0;
			end
			JOB_PERIOD_R: begin
				div_num  = DW'(dur_q);
				div_den  = steps_r_q;
				div_skip = steps_r_q == 16'd0;
			end
			default: begin
				div_num = '0;
			end
		endcase
	end

	logic [15:0] quot_sat16;
	logic [31:0] quot_sat32;
	logic [31:0] quot_period;

	assign quot_sat16  = (64'(quot) > 64'h0000_FFFF) ? 16'hFFFF : quot[15:0];
	assign quot_sat32  = (64'(quot) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
	assign quot_period = (quot == '0) ? 32'd1 : quot[31:0];

	// Tick evaluation on the already advanced millisecond count.
	logic [31:0] now;
	logic        in_move, fire_l, fire_r, next_active;
	logic [32:0] sum_l, sum_r;
	logic [31:0] new_tim_l, new_tim_r;

	assign now         = {elapsed_q, 8'h00};
	assign in_move     = now <= dur_q;
	assign fire_l      = in_move && (per_l_q != 32'd0) && (now >= tim_l_q);
	assign fire_r      = in_move && (per_r_q != 32'd0) && (now >= tim_r_q);
	assign sum_l       = {1'b0, now} + {1'b0, per_l_q};
	assign sum_r       = {1'b0, now} + {1'b0, per_r_q};
	assign new_tim_l   = sum_l[32] ? 32'hFFFF_FFFF : sum_l[31:0];
	assign new_tim_r   = sum_r[32] ? 32'hFFFF_FFFF : sum_r[31:0];
	assign next_active = ({1'b0, now} + 33'd256) <= {1'b0, dur_q};

	ppmp_isqrt #(.LW(LW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.root     (root),
		.done     (sqrt_done)
	);

	ppmp_divider #(.NW(DW)) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == OP_MOVE && !active_q) begin
						state_d = ST_SQUARE;
					end else if (s_tuser == OP_TICK && active_q) begin
						state_d = ST_TICK_INC;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SQUARE: begin
				state_d = ST_ROOT_GO;
			end
			ST_ROOT_GO: begin
				sqrt_start = 1'b1;
				state_d    = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (sqrt_done) begin
					state_d = (k_q == 2'd3) ? ST_DIFF : ST_SQUARE;
				end
			end
			ST_DIFF: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				if (div_skip) begin
					state_d = (j_q == JOB_PERIOD_R) ? ST_COMMIT : ST_DIV_GO;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (j_q == JOB_PERIOD_R) ? ST_COMMIT : ST_DIV_GO;
				end
			end
			ST_COMMIT: begin
				state_d = ST_OUT;
			end
			ST_TICK_INC: begin
				state_d = ST_TICK_EVAL;
			end
			ST_TICK_EVAL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q <= RST_STEP_LENGTH;
			feed_q     <= RST_FEED_SPEED;
			md_q       <= RST_MOTOR_DISTANCE;
			sh_q       <= RST_START_HEIGHT;
			px_q       <= C'(RST_MOTOR_DISTANCE[11:1]);
			py_q       <= C'(RST_START_HEIGHT);
			elapsed_q  <= '0;
			dur_q      <= '0;
			per_l_q    <= '0;
			per_r_q    <= '0;
			tim_l_q    <= '0;
			tim_r_q    <= '0;
			dir_q      <= '0;
			active_q   <= 1'b0;
			k_q        <= '0;
			j_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					j_q <= JOB_STEPS_L;
				end
				ST_ROOT_WAIT: begin
					if (sqrt_done) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DIFF: begin
					dir_q <= {out_r, out_l};
				end
				ST_DIV_GO: begin
					if (div_skip) begin
						if (j_q == JOB_PERIOD_L) begin
							per_l_q <= '0;
						end else begin
							per_r_q <= '0;
						end
						j_q <= j_q + 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (j_q == JOB_DURATION) begin
							dur_q <= quot_sat32;
						end
						if (j_q == JOB_PERIOD_L) begin
							per_l_q <= quot_period;
						end
						if (j_q == JOB_PERIOD_R) begin
							per_r_q <= quot_period;
						end
						j_q <= j_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					tim_l_q   <= per_l_q;
					tim_r_q   <= per_r_q;
					elapsed_q <= '0;
					px_q      <= tx_q;
					py_q      <= ty_q;
					active_q  <= dur_q >= 32'd256;
				end
				ST_TICK_INC: begin
					elapsed_q <= elapsed_q + 1'b1;
				end
				ST_TICK_EVAL: begin
					if (fire_l) begin
						tim_l_q <= new_tim_l;
					end
					if (fire_r) begin
						tim_r_q <= new_tim_r;
					end
					active_q <= next_active;
				end
				default: begin
					k_q <= k_q;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_LENGTH: begin
						step_len_q <= cfg_data;
					end
					REG_FEED_SPEED: begin
						feed_q <= cfg_data[9:0];
					end
					REG_MOTOR_DISTANCE: begin
						md_q <= cfg_data[11:0];
						px_q <= C'(cfg_data[11:1]);
						py_q <= C'(sh_q);
					end
					REG_START_HEIGHT: begin
						sh_q <= cfg_data[11:0];
						px_q <= C'(md_q[11:1]);
						py_q <= C'(cfg_data[11:0]);
					end
					default: begin
						sh_q <= sh_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= s_tuser;
					tx_q <= s_tdata[C-1:0];
					ty_q <= s_tdata[2*C-1:C];
					// A move while busy is refused; an idle tick reports nothing moving.
					out_q <= {(s_tuser == OP_MOVE) && active_q, active_q, 2'b00, 32'd0,
						16'd0, 16'd0, dir_q[1], dir_q[0]};
				end
			end
			ST_SQUARE: begin
				sq_a_q <= sq_x;
				sq_b_q <= sq_y;
			end
			ST_ROOT_WAIT: begin
				if (sqrt_done) begin
					len_q[k_q] <= root;
				end
			end
			ST_DIFF: begin
				ml_q   <= ml;
				mr_q   <= mr;
				prod_q <= mx * MS_PER_S;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (j_q == JOB_STEPS_L) begin
						steps_l_q <= quot_sat16;
					end
					if (j_q == JOB_STEPS_R) begin
						steps_r_q <= quot_sat16;
					end
				end
			end
			ST_COMMIT: begin
				out_q <= {1'b0, dur_q >= 32'd256, 2'b00, dur_q, steps_r_q, steps_l_q,
					dir_q[1], dir_q[0]};
			end
			ST_TICK_EVAL: begin
				out_q <= {out_q.rejected, next_active, fire_r && (op_q == OP_TICK),
					fire_l && (op_q == OP_TICK), out_q[65:0]};
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign m_tdata = {2'b00, out_q};

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides open together");

	a_reject_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.rejected |-> out_q.moving && out_q.move_duration == 32'd0)
		else $error("rejected move without an active move");

	a_pulse_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.pulse_left || out_q.pulse_right)
		|-> out_q.steps_left == 16'd0 && out_q.move_duration == 32'd0 && !out_q.rejected)
		else $error("step pulse on a move result");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |=> m_tvalid && !s_tready)
		else $error("planned move not presented");

endmodule

// File: tb/tb_checker.sv
// Checker for the polar plotter move planner: predicts every result beat and compares it.
// Watches the input, output and configuration ports of the block; depends on ppmp_pkg.
module tb_checker
	import ppmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        s_tuser,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] step_len;
	logic [9:0]  feed;
	logic [11:0] motor_dist;
	logic [11:0] height;
	logic [11:0] pos_x, pos_y;
	logic [23:0] elapsed;
	logic [31:0] dur_left, per_l, per_r, tmr_l, tmr_r;
	logic [1:0]  dirs;
	logic        busy;
	result_t     plan_q[$];
	int          mismatches;

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] string_len(logic [63:0] a, logic [63:0] b);
		return root64((a * a + b * b) << 16);
	endfunction

	function automatic logic [63:0] right_span(logic [11:0] x);
		return (motor_dist >= x) ? 64'(motor_dist - x) : 64'(x - motor_dist);
	endfunction

	function automatic logic [15:0] steps_for(logic [63:0] mag);
		logic [63:0] s;
		s = (mag << 8) / ((step_len == 0) ? 64'd1 : 64'(step_len));
		return (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [31:0] period_of(logic [31:0] d, logic [15:0] s);
		logic [31:0] p;
		if (s == 0) return 32'd0;
		p = d / 32'(s);
		return (p == 0) ? 32'd1 : p;
	endfunction

	function automatic logic [31:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
	endfunction

	task automatic plan_item(logic op, logic [11:0] tx, logic [11:0] ty);
		result_t r;
		logic [63:0] l0, r0, l1, r1, ml, mr, mx, d, nw;
		r = '0;
		if (op == OP_MOVE) begin
			if (busy) begin
				r.rejected = 1'b1;
			end else begin
				l0 = string_len(64'(pos_x), 64'(pos_y));
				r0 = string_len(right_span(pos_x), 64'(pos_y));
				l1 = string_len(64'(tx), 64'(ty));
				r1 = string_len(right_span(tx), 64'(ty));
				ml = (l1 > l0) ? l1 - l0 : l0 - l1;
				mr = (r1 > r0) ? r1 - r0 : r0 - r1;
				mx = (ml > mr) ? ml : mr;
				d = (mx * 64'd1000) / ((feed == 0) ? 64'd1 : 64'(feed));
				dirs = {r1 > r0, l1 > l0};
				r.steps_left = steps_for(ml);
				r.steps_right = steps_for(mr);
				r.move_duration = (d > 64'hFFFFFFFF) ? 32'hFFFFFFFF : d[31:0];
				dur_left = r.move_duration;
				per_l = period_of(dur_left, r.steps_left);
				per_r = period_of(dur_left, r.steps_right);
				tmr_l = per_l;
				tmr_r = per_r;
				elapsed = 24'd0;
				pos_x = tx;
				pos_y = ty;
				busy = dur_left >= 32'd256;
			end
		end else if (busy) begin
			elapsed = elapsed + 24'd1;
			nw = 64'(elapsed) << 8;
			if (nw <= 64'(dur_left)) begin
				if (per_l != 0 && nw >= 64'(tmr_l)) begin
					r.pulse_left = 1'b1;
					tmr_l = sat_sum(nw, 64'(per_l));
				end
				if (per_r != 0 && nw >= 64'(tmr_r)) begin
					r.pulse_right = 1'b1;
					tmr_r = sat_sum(nw, 64'(per_r));
				end
			end
			busy = (nw + 64'd256) <= 64'(dur_left);
		end
		r.reel_out_left = dirs[0];
		r.reel_out_right = dirs[1];
		r.moving = busy;
		plan_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			step_len = RST_STEP_LENGTH;
			feed = RST_FEED_SPEED;
			motor_dist = RST_MOTOR_DISTANCE;
			height = RST_START_HEIGHT;
			pos_x = motor_dist >> 1;
			pos_y = height;
			elapsed = '0;
			dur_left = '0;
			per_l = '0;
			per_r = '0;
			tmr_l = '0;
			tmr_r = '0;
			dirs = '0;
			busy = 1'b0;
			plan_q.delete();
			fail_count = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_STEP_LENGTH: step_len = cfg_data;
				REG_FEED_SPEED: feed = cfg_data[9:0];
				REG_MOTOR_DISTANCE: begin
					motor_dist = cfg_data[11:0];
					pos_x = motor_dist >> 1;
					pos_y = height;
				end
				REG_START_HEIGHT: begin
					height = cfg_data[11:0];
					pos_x = motor_dist >> 1;
					pos_y = height;
				end
				default: begin
					step_len = step_len;
				end
				endcase
			end
			if (s_tvalid && s_tready)
				plan_item(s_tuser, s_tdata[11:0], s_tdata[23:12]);
			if (m_tvalid && m_tready) begin
				got = m_tdata[69:0];
				if (plan_q.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = plan_q.pop_front();
					if (got !== want || m_tdata[71:70] !== 2'b00) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("mismatch: expected %h actual %h", want, m_tdata);
					end
				end
			end
		end
		pending = plan_q.size();
	end
endmodule

// File: tb/tb_top.sv
// Top of the move planner testbench: clock, reset, stimulus, configuration and verdict.
// Instantiates polar_plotter_move_planner and tb_checker; depends on ppmp_pkg.
module tb_top;
	import ppmp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic        s_tuser = 0;
	logic [23:0] s_tdata = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [71:0] m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;
	int          fail_count, pending;
	int          stall_mode = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	polar_plotter_move_planner u_top (.*);

	tb_checker u_chk (.*);

	// The receiver changes its stall pattern at random.
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
		0: m_tready <= 1;
		1: m_tready <= ($urandom_range(0, 3) != 0);
		2: m_tready <= ($urandom_range(0, 3) == 0);
		default: m_tready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	// The beat stays valid after acceptance; the next beat or a gap replaces it in the same step.
	task automatic send_beat(logic op, logic [11:0] x, logic [11:0] y);
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
		if (n != 0) s_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// A move followed by max_ticks beats, mostly ticks, with the odd random move and gaps as noise.
	task automatic run_move(logic [11:0] x, logic [11:0] y, int max_ticks);
		int k;
		send_beat(OP_MOVE, x, y);
		for (k = 0; k < max_ticks; k++) begin
			gap();
			if ($urandom_range(0, 19) == 0)
				send_beat(OP_MOVE, 12'($urandom), 12'($urandom));
			else
				send_beat(OP_TICK, 12'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		#10ms;
		$display("FAIL polar_plotter_move_planner");
		$finish;
	end

	initial begin
		int i, phase;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed part: idle tick, extremes, beyond the motors, rejection, short period.
		send_beat(OP_TICK, 12'hFFF, 12'hFFF);
		run_move(12'd475, 12'd262, 4);
		send_beat(OP_MOVE, 12'd475, 12'd260);
		run_move(12'hFFF, 12'hFFF, 6);
		run_move(12'd0, 12'd0, 4);
		run_move(12'd0, 12'd0, 2);
		write_reg(REG_STEP_LENGTH, 16'd1);
		write_reg(REG_FEED_SPEED, 16'd1000);
		run_move(12'd2000, 12'd10, 6);
		write_reg(REG_STEP_LENGTH, 16'hFFFF);
		write_reg(REG_FEED_SPEED, 16'd1);
		run_move(12'd100, 12'd100, 5);
		write_reg(REG_MOTOR_DISTANCE, 16'hFFF);
		write_reg(REG_START_HEIGHT, 16'd0);
		run_move(12'd2048, 12'd1, 3);
		// Random phases with fresh settings; most moves are short, within ten units of the pen.
		for (phase = 0; phase < 8; phase++) begin
			write_reg(REG_STEP_LENGTH, 16'((phase == 0) ? 0 : $urandom_range(1, 65535)));
			write_reg(REG_FEED_SPEED, 16'((phase == 1) ? 0 : $urandom_range(200, 1000)));
			write_reg(REG_MOTOR_DISTANCE, 16'((phase == 2) ? 1 : $urandom_range(1, 4095)));
			write_reg(REG_START_HEIGHT, 16'($urandom_range(0, 4095)));
			for (i = 0; i < 4; i++) begin
				if ($urandom_range(0, 3) == 0)
					run_move(12'($urandom), 12'($urandom), int'($urandom_range(0, 25)));
				else
					run_move(12'(u_chk.pos_x + $urandom_range(0, 20) - 10),
						12'(u_chk.pos_y + $urandom_range(0, 20) - 10),
						int'($urandom_range(5, 25)));
			end
		end
		write_reg(REG_STEP_LENGTH, RST_STEP_LENGTH);
		write_reg(REG_FEED_SPEED, 16'(RST_FEED_SPEED));
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("PASS polar_plotter_move_planner");
		else
			$display("FAIL polar_plotter_move_planner");
		$finish;
	end
endmodule

// File: polar_plotter_move_planner.f
hdl/ppmp_pkg.sv
hdl/ppmp_isqrt.sv
hdl/ppmp_divider.sv
hdl/polar_plotter_move_planner.sv
tb/tb_checker.sv
tb/tb_top.sv
